@@ rtl/core/vlas_pkg.sv @@
// ----------------------------------------------------------------------------
// vlas_pkg: shared types and constants
// Command, operation and mode codes, colors and the result record used by
// the light animation sequencer.
// ----------------------------------------------------------------------------
package vlas_pkg;

    localparam logic [8:0] MAX_PIXELS = 9'd256;

    // command codes (s_tuser)
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_STOP   = 2'd2;
    localparam logic [1:0] FUNC_STATIC = 2'd3;

    // frame operation codes (m_tuser)
    localparam logic [2:0] OP_SAVE    = 3'd0;
    localparam logic [2:0] OP_RESTORE = 3'd1;
    localparam logic [2:0] OP_PAINT   = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_CHASE   = 3'd4;

    // active animation
    localparam logic [2:0] MODE_NONE        = 3'd0;
    localparam logic [2:0] MODE_BLINK_LEFT  = 3'd1;
    localparam logic [2:0] MODE_BLINK_RIGHT = 3'd2;
    localparam logic [2:0] MODE_BLINK_ALL   = 3'd3;
    localparam logic [2:0] MODE_POLICE      = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
    localparam logic [1:0] REG_BLINK_IVL   = 2'd1;
    localparam logic [1:0] REG_POLICE_IVL  = 2'd2;

    localparam logic [23:0] COLOR_ORANGE = 24'hFF3200;
    localparam logic [23:0] COLOR_BLUE   = 24'h0000FF;
    localparam logic [23:0] COLOR_RED    = 24'hFF0000;

    localparam logic [1:0] FLASHES     = 2'd3;
    localparam logic [3:0] MAX_CYCLES  = 4'd10;
    localparam logic [9:0] CHASE_WIDTH = 10'd3;
    localparam logic [9:0] CHASE_GAP   = 10'd8;

    typedef struct packed {
        logic [8:0]  pixel_count;
        logic [15:0] blink_ivl;
        logic [15:0] police_ivl;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  frame_op;
        logic [8:0]  seg_a_start;
        logic [8:0]  seg_a_end;
        logic [23:0] seg_a_color;
        logic [8:0]  seg_b_start;
        logic [8:0]  seg_b_end;
        logic [23:0] seg_b_color;
    } result_t;

endpackage

@@ rtl/core/vehicle_light_animation_sequencer.sv @@
// ----------------------------------------------------------------------------
// vehicle_light_animation_sequencer: LED strip animation sequencer
// Steps blink and police animations on millisecond ticks and sends frame
// descriptors to a downstream pixel store.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_axis    in         command: tuser func, tdata anim_mode
//  m_axis    out        frame descriptor: tuser frame_op, tdata ranges/colors
//  cfg       in         register write: index, data
//
//  One command is taken per cycle while s_tready is high; its descriptor, if
//  any, is registered. A two-entry output buffer (result register plus skid
//  register) lets s_tready stay high while one descriptor waits.
//  Reset clears animation state and loads register defaults.
// ----------------------------------------------------------------------------
module vehicle_light_animation_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] anim_mode
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // seg_a_start, seg_a_end, seg_a_color,
                                   // seg_b_start, seg_b_end, seg_b_color
    output logic [2:0]  m_tuser,   // [2:0] frame_op
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    vlas_pkg::cfg_t    cfg_reg;
    vlas_pkg::result_t res;
    vlas_pkg::result_t out_reg;
    vlas_pkg::result_t skid_reg;
    logic              res_valid;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              in_accept;
    logic              push;
    logic              pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~skid_valid_reg;
    assign in_accept = s_tvalid & s_tready;
    assign push      = in_accept & res_valid;
    assign pop       = out_valid_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_count <= 9'd64;
            cfg_reg.blink_ivl   <= 16'd500;
            cfg_reg.police_ivl  <= 16'd60;
        end else if (cfg_valid) begin
            case (cfg_index)
                vlas_pkg::REG_PIXEL_COUNT: cfg_reg.pixel_count <= cfg_wdata[8:0];
                vlas_pkg::REG_BLINK_IVL:   cfg_reg.blink_ivl   <= cfg_wdata;
                vlas_pkg::REG_POLICE_IVL:  cfg_reg.police_ivl  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vlas_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .in_func      (s_tuser),
        .in_anim_mode (s_tdata[1:0]),
        .cfg          (cfg_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // output buffer: skid takes a result only while the output register is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.frame_op;
    assign m_tdata  = {4'b0, out_reg.seg_b_color, out_reg.seg_b_end, out_reg.seg_b_start,
                       out_reg.seg_a_color, out_reg.seg_a_end, out_reg.seg_a_start};

endmodule

@@ rtl/core/vlas_core.sv @@
// ----------------------------------------------------------------------------
// vlas_core: animation state and step logic
// Holds the animation state, updates it on each accepted command and
// combinationally forms the frame descriptor that the command causes.
// ----------------------------------------------------------------------------
module vlas_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [1:0]        in_func,
    input  logic [1:0]        in_anim_mode,
    input  vlas_pkg::cfg_t    cfg,
    output logic              res_valid,
    output vlas_pkg::result_t res
);

    logic [2:0]  mode_reg,  mode_next;
    logic        phase_reg, phase_next;
    logic [15:0] ms_reg,    ms_next;
    logic [1:0]  fc_reg,    fc_next;
    logic [3:0]  fcc_reg,   fcc_next;
    logic        blue_reg,  blue_next;
    logic [8:0]  chase_reg, chase_next;

    logic [8:0]  n;
    logic [8:0]  quarter;
    logic [8:0]  half;
    logic [15:0] ms_inc;
    logic [15:0] interval;
    logic [9:0]  c_lo;
    logic [9:0]  c_hi;
    logic [1:0]  fc_inc;

    function automatic logic [8:0] clip(input logic [9:0] v, input logic [8:0] lim);
        logic [9:0] lim_w;
        lim_w = {1'b0, lim};
        clip = (v < lim_w) ? v[8:0] : lim;
    endfunction

    assign n       = (cfg.pixel_count > vlas_pkg::MAX_PIXELS) ? vlas_pkg::MAX_PIXELS
                                                               : cfg.pixel_count;
    assign quarter = n >> 2;
    assign half    = n >> 1;
    assign ms_inc  = (ms_reg == 16'hFFFF) ? ms_reg : ms_reg + 16'd1;
    assign interval = (mode_reg == vlas_pkg::MODE_POLICE) ? cfg.police_ivl : cfg.blink_ivl;
    assign c_lo    = {1'b0, chase_reg};
    assign c_hi    = c_lo + vlas_pkg::CHASE_WIDTH;
    assign fc_inc  = fc_reg + 2'd1;

    always_comb begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        ms_next    = ms_reg;
        fc_next    = fc_reg;
        fcc_next   = fcc_reg;
        blue_next  = blue_reg;
        chase_next = chase_reg;
        res_valid  = 1'b0;
        res        = '0;

        case (in_func)
            vlas_pkg::FUNC_START: begin
                res_valid    = 1'b1;
                res.frame_op = vlas_pkg::OP_SAVE;
                mode_next    = {1'b0, in_anim_mode} + 3'd1;
            end
            vlas_pkg::FUNC_STOP: begin
                res_valid    = 1'b1;
                res.frame_op = vlas_pkg::OP_RESTORE;
                mode_next    = vlas_pkg::MODE_NONE;
            end
            vlas_pkg::FUNC_STATIC: begin
                mode_next = vlas_pkg::MODE_NONE;
            end
            default: begin
                ms_next = ms_inc;
                if (mode_reg != vlas_pkg::MODE_NONE && ms_inc >= interval) begin
                    ms_next    = '0;
                    res_valid  = 1'b1;
                    phase_next = ~phase_reg;
                    if (mode_reg inside {vlas_pkg::MODE_BLINK_LEFT, vlas_pkg::MODE_BLINK_RIGHT,
                                         vlas_pkg::MODE_BLINK_ALL}) begin
                        if (phase_reg) begin
                            res.frame_op    = vlas_pkg::OP_PAINT;
                            res.seg_a_color = vlas_pkg::COLOR_ORANGE;
                            if (mode_reg == vlas_pkg::MODE_BLINK_LEFT) begin
                                res.seg_a_end = quarter;
                            end else if (mode_reg == vlas_pkg::MODE_BLINK_RIGHT) begin
                                res.seg_a_start = n - quarter;
                                res.seg_a_end   = n;
                            end else begin
                                res.seg_a_end = n;
                            end
                        end else begin
                            res.frame_op = vlas_pkg::OP_RESTORE;
                        end
                    end else if (fcc_reg < vlas_pkg::MAX_CYCLES) begin
                        if (phase_reg) begin
                            res.frame_op = vlas_pkg::OP_PAINT;
                            if (blue_reg) begin
                                res.seg_a_end   = half;
                                res.seg_a_color = vlas_pkg::COLOR_BLUE;
                            end else begin
                                res.seg_a_start = half;
                                res.seg_a_end   = n;
                                res.seg_a_color = vlas_pkg::COLOR_RED;
                            end
                        end else begin
                            res.frame_op = vlas_pkg::OP_CLEAR;
                            if (fc_inc >= vlas_pkg::FLASHES) begin
                                blue_next = ~blue_reg;
                                fc_next   = '0;
                                fcc_next  = fcc_reg + 4'd1;
                            end else begin
                                fc_next = fc_inc;
                            end
                        end
                    end else begin
                        // chase: blue leads, red trails by the gap
                        res.frame_op    = vlas_pkg::OP_CHASE;
                        res.seg_a_start = clip(c_lo, n);
                        res.seg_a_end   = clip(c_hi, n);
                        res.seg_a_color = vlas_pkg::COLOR_BLUE;
                        res.seg_b_start = clip((c_lo >= vlas_pkg::CHASE_GAP)
                                               ? c_lo - vlas_pkg::CHASE_GAP : 10'd0, n);
                        res.seg_b_end   = clip((c_hi >= vlas_pkg::CHASE_GAP)
                                               ? c_hi - vlas_pkg::CHASE_GAP : 10'd0, n);
                        res.seg_b_color = vlas_pkg::COLOR_RED;
                        if (c_hi >= ({1'b0, n} + vlas_pkg::CHASE_GAP)) begin
                            chase_next = '0;
                            fcc_next   = '0;
                        end else begin
                            chase_next = c_hi[8:0];
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= vlas_pkg::MODE_NONE;
            phase_reg <= 1'b0;
            ms_reg    <= '0;
            fc_reg    <= '0;
            fcc_reg   <= '0;
            blue_reg  <= 1'b1;
            chase_reg <= '0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            ms_reg    <= ms_next;
            fc_reg    <= fc_next;
            fcc_reg   <= fcc_next;
            blue_reg  <= blue_next;
            chase_reg <= chase_next;
        end
    end

endmodule

@@ rtl/core/vlas_checker.sv @@
// ----------------------------------------------------------------------------
// vlas_checker: port-level checks for the sequencer
// Watches the top-level ports and flags descriptor and ordering errors.
// ----------------------------------------------------------------------------
module vlas_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic [87:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_op_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= vlas_pkg::OP_CHASE)
        else $error("frame operation out of range");

    a_start_save: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == vlas_pkg::FUNC_START && !m_tvalid
        |=> m_tvalid && m_tuser == vlas_pkg::OP_SAVE)
        else $error("start did not produce a save");

    a_plain_ops_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == vlas_pkg::OP_SAVE || m_tuser == vlas_pkg::OP_RESTORE ||
                     m_tuser == vlas_pkg::OP_CLEAR) |-> m_tdata == '0)
        else $error("unused descriptor fields not zero");

    a_paint_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == vlas_pkg::OP_PAINT |-> m_tdata[17:9] >= m_tdata[8:0])
        else $error("paint range reversed");

endmodule

bind vehicle_light_animation_sequencer vlas_checker u_vlas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
